// File: hw/rtl/arpc_pkg.sv
// Shared definitions for the ARP responder and address cache.
// Holds table sizing, ARP header constants, register indexes and the control store.
// No dependencies.

package arpc_pkg;

	// Table sizing
	localparam int TABLE_DEPTH = 16;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int UPC_W       = 4;

	// Field widths fixed by the interface
	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int FLEN_W  = 11;
	localparam int CNT_O_W = 5;
	localparam int CFG_W   = 48;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd1;

	// ARP header constants
	localparam logic [FLEN_W-1:0] MIN_FRAME_LEN = 11'd42;
	localparam logic [15:0]       HTYPE_ETH     = 16'h0001;
	localparam logic [15:0]       PTYPE_IPV4    = 16'h0800;
	localparam logic [7:0]        HLEN_ETH      = 8'd6;
	localparam logic [7:0]        PLEN_IPV4     = 8'd4;
	localparam logic [15:0]       OP_REQUEST    = 16'h0001;
	localparam logic [15:0]       OP_REPLY      = 16'h0002;

	// Control store addresses
	localparam logic [UPC_W-1:0] STEP_EMIT     = 4'd0;
	localparam logic [UPC_W-1:0] STEP_FETCH    = 4'd1;
	localparam logic [UPC_W-1:0] STEP_DISPATCH = 4'd2;
	localparam logic [UPC_W-1:0] STEP_CHKF     = 4'd3;
	localparam logic [UPC_W-1:0] STEP_CHKOP    = 4'd4;
	localparam logic [UPC_W-1:0] STEP_CHKREQ   = 4'd5;
	localparam logic [UPC_W-1:0] STEP_REQ      = 4'd6;
	localparam logic [UPC_W-1:0] STEP_CHKFULL  = 4'd7;
	localparam logic [UPC_W-1:0] STEP_STORE    = 4'd8;
	localparam logic [UPC_W-1:0] STEP_DROP     = 4'd9;
	localparam logic [UPC_W-1:0] STEP_SCHK     = 4'd10;
	localparam logic [UPC_W-1:0] STEP_SCMP     = 4'd11;
	localparam logic [UPC_W-1:0] STEP_SNEXT    = 4'd12;
	localparam logic [UPC_W-1:0] STEP_SHIT     = 4'd13;

	// Jump conditions
	typedef enum logic [3:0] {
		COND_ALWAYS,
		COND_NO_IN,
		COND_IS_LOOKUP,
		COND_FRAME_BAD,
		COND_IS_REP,
		COND_NOT_REQ,
		COND_FULL,
		COND_IDX_END,
		COND_HIT,
		COND_OUT_BLOCKED
	} cond_t;

	// One control word: jump condition and target, then datapath strobes
	typedef struct packed {
		cond_t            cond;
		logic [UPC_W-1:0] target;
		logic             accept;
		logic             emit;
		logic             set_reply;
		logic             tbl_wr;
		logic             set_drop;
		logic             idx_inc;
		logic             set_hit;
	} ctrl_t;

	// Flags returned by the datapath for jump decisions
	typedef struct packed {
		logic in_valid;
		logic is_lookup;
		logic frame_bad;
		logic is_rep;
		logic not_req;
		logic full;
		logic idx_end;
		logic hit;
		logic out_blocked;
	} status_t;

	// Control store: jump taken when the condition holds, else fall through
	function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
		ctrl_t w;
		w           = '0;
		w.cond      = COND_ALWAYS;
		w.target    = STEP_EMIT;
		case (addr)
			STEP_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = COND_OUT_BLOCKED;
				w.target = STEP_EMIT;
			end
			STEP_FETCH: begin
				w.accept = 1'b1;
				w.cond   = COND_NO_IN;
				w.target = STEP_FETCH;
			end
			STEP_DISPATCH: begin
				w.cond   = COND_IS_LOOKUP;
				w.target = STEP_SCHK;
			end
			STEP_CHKF: begin
				w.cond   = COND_FRAME_BAD;
				w.target = STEP_EMIT;
			end
			STEP_CHKOP: begin
				w.cond   = COND_IS_REP;
				w.target = STEP_CHKFULL;
			end
			STEP_CHKREQ: begin
				w.cond   = COND_NOT_REQ;
				w.target = STEP_EMIT;
			end
			STEP_REQ: begin
				w.set_reply = 1'b1;
			end
			STEP_CHKFULL: begin
				w.cond   = COND_FULL;
				w.target = STEP_DROP;
			end
			STEP_STORE: begin
				w.tbl_wr = 1'b1;
			end
			STEP_DROP: begin
				w.set_drop = 1'b1;
			end
			STEP_SCHK: begin
				w.cond   = COND_IDX_END;
				w.target = STEP_EMIT;
			end
			STEP_SCMP: begin
				w.cond   = COND_HIT;
				w.target = STEP_SHIT;
			end
			STEP_SNEXT: begin
				w.idx_inc = 1'b1;
				w.target  = STEP_SCHK;
			end
			STEP_SHIT: begin
				w.set_hit = 1'b1;
			end
			default: begin
				w.target = STEP_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/arpc_table.sv
// Append-only address table: one write port, one read port with registered data.
// Depends on arpc_pkg for depth and widths.

module arpc_table (
	input  logic                        clk,
	input  logic                        we,
	input  logic [arpc_pkg::IDX_W-1:0]  waddr,
	input  logic [arpc_pkg::IP_W-1:0]   wip,
	input  logic [arpc_pkg::MAC_W-1:0]  wmac,
	input  logic [arpc_pkg::IDX_W-1:0]  raddr,
	output logic [arpc_pkg::IP_W-1:0]   rip,
	output logic [arpc_pkg::MAC_W-1:0]  rmac
);

	logic [arpc_pkg::IP_W-1:0]  ip_mem  [arpc_pkg::TABLE_DEPTH];
	logic [arpc_pkg::MAC_W-1:0] mac_mem [arpc_pkg::TABLE_DEPTH];

	// Write the appended entry
	always_ff @(posedge clk) begin
		if (we) begin
			ip_mem[waddr]  <= wip;
			mac_mem[waddr] <= wmac;
		end
	end

	// Register the read data every cycle
	always_ff @(posedge clk) begin
		rip  <= ip_mem[raddr];
		rmac <= mac_mem[raddr];
	end

endmodule

// File: hw/rtl/arpc_seq.sv
// Microcode sequencer: step counter, control store fetch and conditional jumps.
// Depends on arpc_pkg for the control word, status flags and the program.

module arpc_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  arpc_pkg::status_t   status,
	output arpc_pkg::ctrl_t     ctrl
);

	logic [arpc_pkg::UPC_W-1:0] pc_q;
	logic                       take;

	// Fetch the control word for the current step
	assign ctrl = arpc_pkg::ucode(pc_q);

	// Evaluate the jump condition
	always_comb begin
		case (ctrl.cond)
			arpc_pkg::COND_ALWAYS:      take = 1'b1;
			arpc_pkg::COND_NO_IN:       take = !status.in_valid;
			arpc_pkg::COND_IS_LOOKUP:   take = status.is_lookup;
			arpc_pkg::COND_FRAME_BAD:   take = status.frame_bad;
			arpc_pkg::COND_IS_REP:      take = status.is_rep;
			arpc_pkg::COND_NOT_REQ:     take = status.not_req;
			arpc_pkg::COND_FULL:        take = status.full;
			arpc_pkg::COND_IDX_END:     take = status.idx_end;
			arpc_pkg::COND_HIT:         take = status.hit;
			arpc_pkg::COND_OUT_BLOCKED: take = status.out_blocked;
			default:                    take = 1'b1;
		endcase
	end

	// Advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= arpc_pkg::STEP_FETCH;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

// File: hw/rtl/arpc_dpath.sv
// Datapath: configuration, captured transaction, fill and search counters,
// result build-up and the output register. Depends on arpc_pkg and arpc_table.

module arpc_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  arpc_pkg::ctrl_t                ctrl,
	output arpc_pkg::status_t              status,
	// configuration
	input  logic                           cfg_we,
	input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arpc_pkg::CFG_W-1:0]     cfg_data,
	// input transaction
	input  logic                           in_valid,
	input  logic                           mode,
	input  logic [arpc_pkg::FLEN_W-1:0]    frame_length,
	input  logic [15:0]                    hw_type,
	input  logic [15:0]                    proto_type,
	input  logic [7:0]                     hw_len,
	input  logic [7:0]                     proto_len,
	input  logic [15:0]                    operation,
	input  logic [arpc_pkg::MAC_W-1:0]     sender_mac,
	input  logic [arpc_pkg::IP_W-1:0]      sender_ip,
	input  logic [arpc_pkg::IP_W-1:0]      target_ip,
	input  logic [arpc_pkg::IP_W-1:0]      lookup_ip,
	// result transaction
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           reply_send,
	output logic [arpc_pkg::MAC_W-1:0]     reply_dest_mac,
	output logic [arpc_pkg::IP_W-1:0]      reply_dest_ip,
	output logic                           learned,
	output logic                           learn_dropped,
	output logic                           lookup_hit,
	output logic [arpc_pkg::MAC_W-1:0]     lookup_mac,
	output logic [arpc_pkg::CNT_O_W-1:0]   entry_count
);

	// The reply builder outside this block supplies the sender MAC, so writes
	// to the own MAC register are taken but no copy is held here.
	logic [arpc_pkg::IP_W-1:0]   own_ip_q;

	logic                        mode_q;
	logic [arpc_pkg::FLEN_W-1:0] flen_q;
	logic [15:0]                 htype_q;
	logic [15:0]                 ptype_q;
	logic [7:0]                  hlen_q;
	logic [7:0]                  plen_q;
	logic [15:0]                 oper_q;
	logic [arpc_pkg::MAC_W-1:0]  smac_q;
	logic [arpc_pkg::IP_W-1:0]   sip_q;
	logic [arpc_pkg::IP_W-1:0]   tip_q;
	logic [arpc_pkg::IP_W-1:0]   key_q;

	logic [arpc_pkg::CNT_W-1:0]  fill_q;
	logic [arpc_pkg::CNT_W-1:0]  idx_q;

	logic                        w_send_q;
	logic [arpc_pkg::MAC_W-1:0]  w_dmac_q;
	logic [arpc_pkg::IP_W-1:0]   w_dip_q;
	logic                        w_learned_q;
	logic                        w_drop_q;
	logic                        w_hit_q;
	logic [arpc_pkg::MAC_W-1:0]  w_lmac_q;

	logic                        out_valid_q;

	logic [arpc_pkg::IP_W-1:0]   rd_ip;
	logic [arpc_pkg::MAC_W-1:0]  rd_mac;
	logic                        in_fire;
	logic                        out_blocked;
	logic                        out_load;

	assign in_fire     = in_valid && ctrl.accept;
	assign out_blocked = out_valid_q && out_stall;
	assign out_load    = ctrl.emit && !out_blocked;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
		end else if (cfg_we && cfg_index == arpc_pkg::REG_OWN_IP) begin
			own_ip_q <= cfg_data[arpc_pkg::IP_W-1:0];
		end
	end

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q  <= mode;
			flen_q  <= frame_length;
			htype_q <= hw_type;
			ptype_q <= proto_type;
			hlen_q  <= hw_len;
			plen_q  <= proto_len;
			oper_q  <= operation;
			smac_q  <= sender_mac;
			sip_q   <= sender_ip;
			tip_q   <= target_ip;
			key_q   <= lookup_ip;
		end
	end

	// Table storage
	arpc_table u_table (
		.clk   (clk),
		.we    (ctrl.tbl_wr),
		.waddr (fill_q[arpc_pkg::IDX_W-1:0]),
		.wip   (sip_q),
		.wmac  (smac_q),
		.raddr (idx_q[arpc_pkg::IDX_W-1:0]),
		.rip   (rd_ip),
		.rmac  (rd_mac)
	);

	// Fill count and search index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
		end else begin
			if (ctrl.tbl_wr) begin
				fill_q <= fill_q + 1'b1;
			end
			if (in_fire) begin
				idx_q <= '0;
			end else if (ctrl.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Build up the result of the transaction in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_send_q    <= 1'b0;
			w_dmac_q    <= '0;
			w_dip_q     <= '0;
			w_learned_q <= 1'b0;
			w_drop_q    <= 1'b0;
			w_hit_q     <= 1'b0;
			w_lmac_q    <= '0;
		end else if (in_fire) begin
			w_send_q    <= 1'b0;
			w_dmac_q    <= '0;
			w_dip_q     <= '0;
			w_learned_q <= 1'b0;
			w_drop_q    <= 1'b0;
			w_hit_q     <= 1'b0;
			w_lmac_q    <= '0;
		end else begin
			if (ctrl.set_reply) begin
				w_send_q <= 1'b1;
				w_dmac_q <= smac_q;
				w_dip_q  <= sip_q;
			end
			if (ctrl.tbl_wr) begin
				w_learned_q <= 1'b1;
			end
			if (ctrl.set_drop) begin
				w_drop_q <= 1'b1;
			end
			if (ctrl.set_hit) begin
				w_hit_q  <= 1'b1;
				w_lmac_q <= rd_mac;
			end
		end
	end

	// Flags for the sequencer
	always_comb begin
		status.in_valid    = in_valid;
		status.is_lookup   = mode_q;
		status.frame_bad   = !(flen_q >= arpc_pkg::MIN_FRAME_LEN
			&& htype_q == arpc_pkg::HTYPE_ETH
			&& ptype_q == arpc_pkg::PTYPE_IPV4
			&& hlen_q == arpc_pkg::HLEN_ETH
			&& plen_q == arpc_pkg::PLEN_IPV4
			&& tip_q == own_ip_q);
		status.is_rep      = (oper_q == arpc_pkg::OP_REPLY);
		status.not_req     = (oper_q != arpc_pkg::OP_REQUEST);
		status.full        = (fill_q == arpc_pkg::CNT_W'(arpc_pkg::TABLE_DEPTH));
		status.idx_end     = (idx_q >= fill_q);
		status.hit         = (rd_ip == key_q);
		status.out_blocked = out_blocked;
	end

	// Output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			reply_send     <= w_send_q;
			reply_dest_mac <= w_dmac_q;
			reply_dest_ip  <= w_dip_q;
			learned        <= w_learned_q;
			learn_dropped  <= w_drop_q;
			lookup_hit     <= w_hit_q;
			lookup_mac     <= w_lmac_q;
			entry_count    <= arpc_pkg::CNT_O_W'(fill_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/arp_responder_and_cache.sv
// Top level of the ARP responder and address cache.
// Depends on arpc_pkg, arpc_seq and arpc_dpath.
//
// Usage:
//   Input channel (in_valid/in_stall) carries either a parsed ARP frame
//   (mode 0) or an address lookup (mode 1). Every input transaction yields
//   exactly one result transaction on the output channel (out_valid/out_stall).
//   A matching request flags a reply to the sender; a matching reply appends
//   the sender's IP and MAC to a 16-entry table; a lookup returns the first
//   matching entry. own_ip and own_mac are written over cfg_we/cfg_index/cfg_data.
// Timing:
//   One transaction at a time, driven by a small microcode program. A frame
//   ends after the header check when that check fails, after the operation
//   check for an unknown operation, and after the reply, store or drop step
//   for a request or a reply. A lookup runs a three-step search loop per
//   entry over the table's single read port, stopping at the first hit or
//   once the fill count is reached. A fetch step lies between transactions.
//   The next transaction is accepted while a finished result waits.
// Reset and stall:
//   Reset empties the table and clears own_ip. While out_stall is high the
//   result holds; one further transaction can be accepted and worked on, and
//   it then waits in the sequencer until the output register frees.

module arp_responder_and_cache (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arpc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [arpc_pkg::FLEN_W-1:0]    frame_length,
	input  logic [15:0]                    hw_type,
	input  logic [15:0]                    proto_type,
	input  logic [7:0]                     hw_len,
	input  logic [7:0]                     proto_len,
	input  logic [15:0]                    operation,
	input  logic [arpc_pkg::MAC_W-1:0]     sender_mac,
	input  logic [arpc_pkg::IP_W-1:0]      sender_ip,
	input  logic [arpc_pkg::IP_W-1:0]      target_ip,
	input  logic [arpc_pkg::IP_W-1:0]      lookup_ip,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           reply_send,
	output logic [arpc_pkg::MAC_W-1:0]     reply_dest_mac,
	output logic [arpc_pkg::IP_W-1:0]      reply_dest_ip,
	output logic                           learned,
	output logic                           learn_dropped,
	output logic                           lookup_hit,
	output logic [arpc_pkg::MAC_W-1:0]     lookup_mac,
	output logic [arpc_pkg::CNT_O_W-1:0]   entry_count
);

	arpc_pkg::ctrl_t   ctrl;
	arpc_pkg::status_t status;

	// Take a transaction only in the fetch step
	assign in_stall = !ctrl.accept;

	arpc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	arpc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.mode           (mode),
		.frame_length   (frame_length),
		.hw_type        (hw_type),
		.proto_type     (proto_type),
		.hw_len         (hw_len),
		.proto_len      (proto_len),
		.operation      (operation),
		.sender_mac     (sender_mac),
		.sender_ip      (sender_ip),
		.target_ip      (target_ip),
		.lookup_ip      (lookup_ip),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.reply_send     (reply_send),
		.reply_dest_mac (reply_dest_mac),
		.reply_dest_ip  (reply_dest_ip),
		.learned        (learned),
		.learn_dropped  (learn_dropped),
		.lookup_hit     (lookup_hit),
		.lookup_mac     (lookup_mac),
		.entry_count    (entry_count)
	);

endmodule

// File: hw/rtl/arpc_checker.sv
// Port-level checks for the ARP responder and address cache, bound to the top.
// Depends on arpc_pkg and on the ports of arp_responder_and_cache.

module arpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           reply_send,
	input logic [arpc_pkg::MAC_W-1:0]     reply_dest_mac,
	input logic [arpc_pkg::IP_W-1:0]      reply_dest_ip,
	input logic                           learned,
	input logic                           learn_dropped,
	input logic                           lookup_hit,
	input logic [arpc_pkg::MAC_W-1:0]     lookup_mac,
	input logic [arpc_pkg::CNT_O_W-1:0]   entry_count
);

	// At most one outcome per result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({reply_send, learned, learn_dropped, lookup_hit}) <= 1)
		else $error("more than one outcome flagged in one result");

	// Reply addresses are zero unless a reply is flagged
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reply_send |-> reply_dest_mac == '0 && reply_dest_ip == '0)
		else $error("reply address without reply_send");

	// Lookup MAC is zero on a miss
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !lookup_hit |-> lookup_mac == '0)
		else $error("lookup_mac non-zero on a miss");

	// A dropped learn happens only with a full table
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && learn_dropped |->
			entry_count == arpc_pkg::CNT_O_W'(arpc_pkg::TABLE_DEPTH))
		else $error("learn dropped while the table has room");

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry_count) && $stable(lookup_mac))
		else $error("stalled result changed");

endmodule

bind arp_responder_and_cache arpc_checker u_arpc_checker (.*);
